// ===== design/teq_pkg.sv =====
package teq_pkg;

  // Field widths of one word on either channel
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned SEC_W         = 32;
  localparam int unsigned NSEC_W        = 30;
  localparam int unsigned HANDLE_W      = 8;
  localparam int unsigned ENTRY_COUNT_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE_DUE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE_NEXT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TEST_HEAD    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR        = 3'd4;

  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [NSEC_W-1:0] nsec;
  } teq_time_t;

  typedef struct packed {
    teq_time_t           tm;
    logic [HANDLE_W-1:0] handle;
  } teq_entry_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [SEC_W-1:0]    time_sec;
    logic [NSEC_W-1:0]   time_nsec;
    logic [HANDLE_W-1:0] handle;
  } teq_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]      out_handle;
    logic                     handle_valid;
    logic                     last_of_run;
    logic                     head_due;
    logic                     queue_empty;
    logic                     insert_rejected;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } teq_out_t;

endpackage

// ===== design/teq_store.sv =====
module teq_store import teq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  teq_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output teq_entry_t    rdata
);

  teq_entry_t mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/teq_cmp.sv =====
module teq_cmp import teq_pkg::*; (
  input  teq_time_t a_tm,
  input  teq_time_t b_tm,
  output logic      le
);

  // Deadline a is at or before b: seconds first, then nanoseconds
  assign le = (a_tm.sec < b_tm.sec) ||
              ((a_tm.sec == b_tm.sec) && (a_tm.nsec <= b_tm.nsec));

endmodule

// ===== design/timed_event_queue.sv =====
// Steps: clear, rejected insert, undefined code, requests on an empty queue and
//   an insert into it answer straight from idle; head test passes S_HEAD_CMP;
//   release next passes S_EMIT_RD, S_EMIT_OUT; insert moves each later entry up
//   (S_INS_RD, S_INS_CMP), then S_INS_WR if all move; release-all scans, then emits.
// One request at a time: busy stays high until the last word is registered.
// Reset clears count, head pointer and sequencer, not entries; no receiver stall.
module timed_event_queue import teq_pkg::*; #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  teq_in_t  in_data,
  output logic     out_valid,
  output teq_out_t out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [HANDLE_W-1:0] HMASK =
    (HANDLE_BITS >= HANDLE_W) ? {HANDLE_W{1'b1}} : HANDLE_W'((1 << HANDLE_BITS) - 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INS_RD   = 9'b000000010,
    S_INS_CMP  = 9'b000000100,
    S_INS_WR   = 9'b000001000,
    S_SCAN_RD  = 9'b000010000,
    S_SCAN_CMP = 9'b000100000,
    S_EMIT_RD  = 9'b001000000,
    S_EMIT_OUT = 9'b010000000,
    S_HEAD_CMP = 9'b100000000
  } teq_state_t;

  teq_state_t     state_r, state_nxt;
  teq_in_t        req_r;
  logic           empty_r;
  logic [AW-1:0]  hd_r, hd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  teq_out_t       out_r, out_nxt;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  teq_entry_t     wdata;
  teq_entry_t     rdata;
  teq_entry_t     ent_in;
  teq_entry_t     ent_req;
  teq_time_t      ref_tm;
  logic           cmp_le;
  logic           accept;

  // Physical slot of the entry at offset off from the head
  function automatic logic [AW-1:0] pos(input logic [AW-1:0] base,
                                        input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign ent_in.tm.sec   = in_data.time_sec;
  assign ent_in.tm.nsec  = in_data.time_nsec;
  assign ent_in.handle   = in_data.handle & HMASK;
  assign ent_req.tm.sec  = req_r.time_sec;
  assign ent_req.tm.nsec = req_r.time_nsec;
  assign ent_req.handle  = req_r.handle & HMASK;
  assign ref_tm          = ent_req.tm;

  teq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shared comparator: stored deadline against the request time
  teq_cmp u_cmp (
    .a_tm (rdata.tm),
    .b_tm (ref_tm),
    .le   (cmp_le)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    hd_nxt        = hd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    we            = 1'b0;
    waddr         = hd_r;
    wdata         = ent_req;
    raddr         = hd_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.req_type)
            REQ_INSERT: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                out_valid_nxt           = 1'b1;
                out_nxt.last_of_run     = 1'b1;
                out_nxt.insert_rejected = 1'b1;
              end else if (cnt_r == '0) begin
                we                  = 1'b1;
                wdata               = ent_in;
                cnt_nxt             = cnt_r + 1'b1;
                out_valid_nxt       = 1'b1;
                out_nxt.last_of_run = 1'b1;
              end else begin
                idx_nxt   = cnt_r;
                state_nxt = S_INS_RD;
              end
            end
            REQ_RELEASE_DUE: begin
              if (cnt_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_nxt.last_of_run = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            REQ_RELEASE_NEXT: begin
              if (cnt_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_nxt.last_of_run = 1'b1;
              end else begin
                idx_nxt   = CW'(1);
                cnt_nxt   = cnt_r - 1'b1;
                state_nxt = S_EMIT_RD;
              end
            end
            REQ_TEST_HEAD: begin
              if (cnt_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_nxt.last_of_run = 1'b1;
              end else begin
                state_nxt = S_HEAD_CMP;
              end
            end
            REQ_CLEAR: begin
              cnt_nxt             = '0;
              out_valid_nxt       = 1'b1;
              out_nxt.last_of_run = 1'b1;
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_nxt.last_of_run = 1'b1;
            end
          endcase
        end
      end
      // Fetch the entry just below the insertion point
      S_INS_RD: begin
        raddr     = pos(hd_r, idx_r - 1'b1);
        state_nxt = S_INS_CMP;
      end
      // Move the later entry up, or drop the new one in place
      S_INS_CMP: begin
        we    = 1'b1;
        waddr = pos(hd_r, idx_r);
        if (cmp_le) begin
          wdata               = ent_req;
          cnt_nxt             = cnt_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_nxt.last_of_run = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          wdata   = rdata;
          idx_nxt = idx_r - 1'b1;
          if (idx_r == CW'(1)) begin
            state_nxt = S_INS_WR;
          end else begin
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_WR: begin
        we                  = 1'b1;
        wdata               = ent_req;
        cnt_nxt             = cnt_r + 1'b1;
        out_valid_nxt       = 1'b1;
        out_nxt.last_of_run = 1'b1;
        state_nxt           = S_IDLE;
      end
      // Count the due entries from the head
      S_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = cnt_r - idx_r;
          state_nxt = S_EMIT_RD;
        end else begin
          raddr     = pos(hd_r, idx_r);
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (cmp_le) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else if (idx_r == '0) begin
          out_valid_nxt       = 1'b1;
          out_nxt.last_of_run = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r - idx_r;
          state_nxt = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_OUT;
      end
      // Release the head entry and advance
      S_EMIT_OUT: begin
        out_valid_nxt        = 1'b1;
        out_nxt.out_handle   = rdata.handle;
        out_nxt.handle_valid = 1'b1;
        out_nxt.last_of_run  = (idx_r == CW'(1));
        hd_nxt               = pos(hd_r, CW'(1));
        idx_nxt              = idx_r - 1'b1;
        if (idx_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_HEAD_CMP: begin
        out_valid_nxt       = 1'b1;
        out_nxt.last_of_run = 1'b1;
        out_nxt.head_due    = cmp_le;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.queue_empty = (state_r == S_IDLE) ? (cnt_r == '0) : empty_r;
    out_nxt.entry_count = ENTRY_COUNT_W'(cnt_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hd_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hd_r        <= hd_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_data;
      empty_r <= (cnt_r == '0);
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_emit_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_OUT) |=> (out_valid && out_data.handle_valid))
    else $error("release step gave no word");

  a_idle_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !start) |=> !out_valid)
    else $error("word given without a request");

  a_flag_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.handle_valid) |->
      (!out_data.insert_rejected && !out_data.head_due))
    else $error("released word carries other flags");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.insert_rejected) |->
      (out_data.entry_count == ENTRY_COUNT_W'(CAPACITY)))
    else $error("insert rejected while not full");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import teq_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned HANDLE_BITS  = 8;
  localparam int unsigned RANDOM_ITEMS = 270;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned PRINT_LIMIT  = 100;

  // Request codes the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam logic [SEC_W-1:0]  SEC_MAX        = '1;
  localparam logic [NSEC_W-1:0] NSEC_MAX       = '1;
  localparam logic [NSEC_W-1:0] NSEC_LAST_GOOD = 30'd999_999_999;
  localparam logic [NSEC_W-1:0] NSEC_BILLION   = 30'd1_000_000_000;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  teq_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  teq_out_t out_data;

  // Shadow of the sorted entry store
  teq_entry_t  shadow [CAPACITY];
  int unsigned shadow_len = 0;

  teq_out_t    predicted_words[$];
  int unsigned mismatch_count = 0;
  int unsigned word_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned max_gap        = 0;
  logic [SEC_W-1:0] epoch     = '0;

  timed_event_queue #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Deadline a is at or before deadline b
  function automatic logic no_later(input teq_time_t a, input teq_time_t b);
    return (a.sec < b.sec) || (a.sec == b.sec && a.nsec <= b.nsec);
  endfunction

  // Apply one request to the shadow store and queue the words it owes
  function automatic void evaluate_request(input teq_in_t w);
    teq_out_t    r;
    teq_time_t   t;
    int unsigned n;
    int unsigned taken;
    t.sec   = w.time_sec;
    t.nsec  = w.time_nsec;
    r       = '0;
    r.last_of_run = 1'b1;
    r.queue_empty = (shadow_len == 0);
    taken   = 0;
    case (w.req_type)
      REQ_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          r.insert_rejected = 1'b1;
        end else begin
          // shift later deadlines up; equal deadlines stay ahead
          n = shadow_len;
          while (n > 0 && !no_later(shadow[n-1].tm, t)) begin
            shadow[n] = shadow[n-1];
            n--;
          end
          shadow[n].tm     = t;
          shadow[n].handle = w.handle;
          shadow_len++;
        end
      end
      REQ_RELEASE_DUE: begin
        while (taken < shadow_len && no_later(shadow[taken].tm, t)) taken++;
      end
      REQ_RELEASE_NEXT: begin
        if (shadow_len > 0) taken = 1;
      end
      REQ_TEST_HEAD: begin
        r.head_due = (shadow_len > 0) && no_later(shadow[0].tm, t);
      end
      REQ_CLEAR: begin
        shadow_len = 0;
      end
      default: ;
    endcase
    if (taken == 0) begin
      r.entry_count = ENTRY_COUNT_W'(shadow_len);
      predicted_words.push_back(r);
    end else begin
      // one word per released entry, earliest first
      for (int unsigned i = 0; i < taken; i++) begin
        r.out_handle   = shadow[i].handle;
        r.handle_valid = 1'b1;
        r.last_of_run  = (i + 1 == taken);
        r.entry_count  = ENTRY_COUNT_W'(shadow_len - taken);
        predicted_words.push_back(r);
      end
      for (int unsigned i = taken; i < shadow_len; i++) shadow[i-taken] = shadow[i];
      shadow_len -= taken;
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t ns: word %0d %s expected %0h got %0h", $time, word_count, what,
               want, seen);
    mismatch_count++;
  endtask

  // Drive one request, holding start until the block takes it
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [SEC_W-1:0] sec,
                           input logic [NSEC_W-1:0] nsec, input logic [HANDLE_W-1:0] hdl);
    teq_in_t     w;
    int unsigned gap;
    w.req_type  = req;
    w.time_sec  = sec;
    w.time_nsec = nsec;
    w.handle    = hdl;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    evaluate_request(w);
  endtask

  // Mostly deadlines close to the epoch so that comparisons matter
  function automatic teq_time_t draw_time();
    teq_time_t   t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      t.sec  = $urandom();
      t.nsec = NSEC_W'($urandom());
    end else begin
      t.sec = epoch + $urandom_range(0, 5);
      pick  = $urandom_range(0, 99);
      if (pick < 25)      t.nsec = '0;
      else if (pick < 50) t.nsec = NSEC_LAST_GOOD;
      else if (pick < 65) t.nsec = NSEC_W'($urandom_range(NSEC_BILLION, NSEC_MAX));
      else                t.nsec = NSEC_W'($urandom_range(0, NSEC_LAST_GOOD));
    end
    return t;
  endfunction

  task automatic send_random(input logic [REQ_W-1:0] req);
    teq_time_t t;
    t = draw_time();
    send_word(req, t.sec, t.nsec, HANDLE_W'($urandom_range(0, 255)));
  endtask

  // Check each word against the oldest prediction
  always @(posedge clk) begin
    teq_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (predicted_words.size() == 0) begin
        flag_mismatch("unexpected word", '0, 32'(out_data));
      end else begin
        want = predicted_words.pop_front();
        if (out_data.out_handle !== want.out_handle)
          flag_mismatch("out_handle", 32'(want.out_handle), 32'(out_data.out_handle));
        if (out_data.handle_valid !== want.handle_valid)
          flag_mismatch("handle_valid", 32'(want.handle_valid),
                        32'(out_data.handle_valid));
        if (out_data.last_of_run !== want.last_of_run)
          flag_mismatch("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
        if (out_data.head_due !== want.head_due)
          flag_mismatch("head_due", 32'(want.head_due), 32'(out_data.head_due));
        if (out_data.queue_empty !== want.queue_empty)
          flag_mismatch("queue_empty", 32'(want.queue_empty), 32'(out_data.queue_empty));
        if (out_data.insert_rejected !== want.insert_rejected)
          flag_mismatch("insert_rejected", 32'(want.insert_rejected),
                        32'(out_data.insert_rejected));
        if (out_data.entry_count !== want.entry_count)
          flag_mismatch("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
      end
      word_count++;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Requests on an empty queue and ignored codes
  task automatic test_empty_queue();
    max_gap = 18;
    send_word(REQ_RELEASE_NEXT, '0, '0, 8'h00);
    send_word(REQ_RELEASE_DUE, SEC_MAX, NSEC_MAX, 8'hFF);
    send_word(REQ_TEST_HEAD, SEC_MAX, NSEC_MAX, 8'h00);
    send_word(REQ_CLEAR, '0, '0, 8'h00);
    send_word(REQ_UNUSED_LO, SEC_MAX, NSEC_MAX, 8'hFF);
    send_word(REQ_UNUSED_HI, '0, '0, 8'h00);
  endtask

  // Deadline ordering, ties, extreme and out-of-range times
  task automatic test_ordering();
    max_gap = 18;
    send_word(REQ_INSERT, SEC_MAX, NSEC_MAX, 8'hFF);
    send_word(REQ_INSERT, '0, '0, 8'h00);
    send_word(REQ_INSERT, 32'd5, NSEC_BILLION, 8'h01);
    send_word(REQ_INSERT, 32'd5, NSEC_LAST_GOOD, 8'h02);
    send_word(REQ_INSERT, 32'd5, NSEC_LAST_GOOD, 8'h03);
    send_word(REQ_TEST_HEAD, '0, '0, 8'h00);
    send_word(REQ_RELEASE_DUE, 32'd5, NSEC_LAST_GOOD, 8'h00);
    send_word(REQ_TEST_HEAD, 32'd5, NSEC_LAST_GOOD, 8'h00);
    send_word(REQ_RELEASE_NEXT, '0, '0, 8'h00);
    send_word(REQ_UNUSED_LO, '0, '0, 8'h00);
    send_word(REQ_RELEASE_DUE, SEC_MAX, NSEC_MAX, 8'h00);
    send_word(REQ_INSERT, 32'd7, '0, 8'hA5);
    send_word(REQ_INSERT, 32'd3, NSEC_MAX, 8'h5A);
    send_word(REQ_CLEAR, '0, '0, 8'h00);
  endtask

  // Fill to capacity back to back, overflow, then release everything
  task automatic test_full_queue();
    max_gap = 0;
    epoch   = $urandom_range(0, 32'hFFFF_FF00);
    while (shadow_len < CAPACITY) send_random(REQ_INSERT);
    send_random(REQ_INSERT);
    send_random(REQ_TEST_HEAD);
    send_word(REQ_RELEASE_DUE, SEC_MAX, NSEC_MAX, 8'h00);
  endtask

  // Mixed traffic with occasional fill bursts and changing idle rates
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 25 == 0) begin
        pick    = $urandom_range(0, 2);
        max_gap = (pick == 0) ? 0 : (pick == 1) ? 4 : 18;
        epoch   = $urandom_range(0, 32'hFFFF_FF00);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_random(REQ_INSERT);
      end else if (pick < 60) begin
        send_random(REQ_RELEASE_DUE);
      end else if (pick < 72) begin
        send_random(REQ_RELEASE_NEXT);
      end else if (pick < 87) begin
        send_random(REQ_TEST_HEAD);
      end else if (pick < 91) begin
        send_random(REQ_CLEAR);
      end else if (pick < 95) begin
        send_random(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)));
      end else begin
        // fill up and push one past the top
        while (shadow_len < CAPACITY) begin
          send_random(REQ_INSERT);
          sent++;
        end
        send_random(REQ_INSERT);
      end
      sent++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_ordering();
    test_full_queue();
    test_random_traffic();
    start <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
